[src/source_tokenizer_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef SOURCE_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SRCTOK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srctok: implication failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SRCTOK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srctok: next-cycle implication failed");

`endif

[src/srctok_pkg.sv]
package srctok_pkg;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_DDOT    = 6'd3;
    localparam logic [5:0] K_DOT     = 6'd2;
    localparam logic [5:0] K_LPAREN  = 6'd4;
    localparam logic [5:0] K_RPAREN  = 6'd5;
    localparam logic [5:0] K_LBRACK  = 6'd6;
    localparam logic [5:0] K_RBRACK  = 6'd7;
    localparam logic [5:0] K_LBRACE  = 6'd8;
    localparam logic [5:0] K_RBRACE  = 6'd9;
    localparam logic [5:0] K_COMMA   = 6'd1;
    localparam logic [5:0] K_ASSIGN  = 6'd10;
    localparam logic [5:0] K_EQ      = 6'd11;
    localparam logic [5:0] K_PLUS    = 6'd12;
    localparam logic [5:0] K_MINUS   = 6'd13;
    localparam logic [5:0] K_ARROW   = 6'd14;
    localparam logic [5:0] K_COLON   = 6'd15;
    localparam logic [5:0] K_DEFINE  = 6'd16;
    localparam logic [5:0] K_SEMI    = 6'd17;
    localparam logic [5:0] K_LT      = 6'd18;
    localparam logic [5:0] K_LE      = 6'd19;
    localparam logic [5:0] K_GT      = 6'd20;
    localparam logic [5:0] K_GE      = 6'd21;
    localparam logic [5:0] K_NOT     = 6'd22;
    localparam logic [5:0] K_NE      = 6'd23;
    localparam logic [5:0] K_BAR     = 6'd24;
    localparam logic [5:0] K_STAR    = 6'd25;
    localparam logic [5:0] K_DIVIDE  = 6'd26;
    localparam logic [5:0] K_HASH    = 6'd27;
    localparam logic [5:0] K_NUMBER  = 6'd28;
    localparam logic [5:0] K_KEYWORD = 6'd29;
    localparam logic [5:0] K_IDENT   = 6'd30;
    localparam logic [5:0] K_GENERIC = 6'd31;
    localparam logic [5:0] K_CHAR    = 6'd32;
    localparam logic [5:0] K_STRING  = 6'd33;
    localparam logic [5:0] K_UNKNOWN = 6'd34;
    localparam logic [5:0] K_TAB     = 6'd35;

    localparam logic [3:0] NO_KEYWORD = 4'd15;
    localparam int         KW_COUNT   = 15;

    localparam logic [63:0] KW_WORD [KW_COUNT] = '{
        "let", "match", "with", "if", "then", "else", "llvm", "extern",
        "fun", "for", "in", "do", "true", "false", "type"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd4, 4'd4, 4'd6,
        4'd3, 4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd4
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [63:0] value;
        logic [3:0]  kw;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
        logic [31:0] col;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [5:0] single;
        logic [7:0] second;
        logic [5:0] twice;
    } op2_t;

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
        logic [7:0] ch;
        ch = 8'd0;
        if (4'(p) < KW_LEN[k])
            ch = KW_WORD[k][8 * (int'(KW_LEN[k]) - 1 - int'(p)) +: 8];
        return ch;
    endfunction

    function automatic op2_t op2_info(input logic [7:0] first);
        op2_t o;
        case (first)
            ".":     o = '{K_DOT,    8'h2e, K_DDOT};
            "=":     o = '{K_ASSIGN, 8'h3d, K_EQ};
            "-":     o = '{K_MINUS,  8'h3e, K_ARROW};
            ":":     o = '{K_COLON,  8'h3d, K_DEFINE};
            "<":     o = '{K_LT,     8'h3d, K_LE};
            ">":     o = '{K_GT,     8'h3d, K_GE};
            default: o = '{K_NOT,    8'h3d, K_NE};
        endcase
        return o;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            ",":     k = K_COMMA;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "+":     k = K_PLUS;
            ";":     k = K_SEMI;
            "|":     k = K_BAR;
            "*":     k = K_STAR;
            "#":     k = K_HASH;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return is_alpha(c) || (c == "_");
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_ident_start(c) || is_digit(c);
    endfunction

endpackage

[src/source_tokenizer_top.sv]
// Channel   Signals                                  Direction  Transaction
// src       src_valid/src_ready, source_byte,        in         one source byte
//           end_of_input
// tok       tok_valid/tok_ready, token_kind ...      out        one token descriptor
//           last_token
// One byte is lexed per cycle; a byte is taken once the tokens of the byte before
// (zero to three) are gone or the last of them leaves in that same cycle, so the rate
// is one byte per cycle while each byte yields at most one token and tok_ready is high;
// otherwise a byte waits. The three-entry result register holds a byte's tokens.
// rst_n clears the scanner to the start of a file; tok_ready low holds results
// and stalls src once the last held token is not taken.
module source_tokenizer_top #(
    parameter int POSITION_BITS      = 32,
    parameter int MAX_KEYWORD_LENGTH = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  logic [7:0]  source_byte,
    input  logic        end_of_input,
    output logic        tok_valid,
    input  logic        tok_ready,
    output logic [5:0]  token_kind,
    output logic [63:0] number_value,
    output logic [3:0]  keyword_index,
    output logic [31:0] start_offset,
    output logic [31:0] token_length,
    output logic [31:0] line_number,
    output logic [31:0] column_number,
    output logic        last_token
);
    import srctok_pkg::*;

    localparam int PB   = POSITION_BITS;
    localparam int IL_W = $clog2(MAX_KEYWORD_LENGTH + 2);

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_SLASH    = 4'd1;
    localparam logic [3:0] M_COMMENT  = 4'd2;
    localparam logic [3:0] M_OP2      = 4'd3;
    localparam logic [3:0] M_ZERO     = 4'd4;
    localparam logic [3:0] M_NUM      = 4'd5;
    localparam logic [3:0] M_IDENT    = 4'd6;
    localparam logic [3:0] M_QUOTE    = 4'd7;
    localparam logic [3:0] M_QUOTE_ID = 4'd8;
    localparam logic [3:0] M_CHAR     = 4'd9;
    localparam logic [3:0] M_GENERIC  = 4'd10;
    localparam logic [3:0] M_STRING   = 4'd11;
    localparam logic [3:0] M_DONE     = 4'd12;

    localparam logic [4:0] BASE_2  = 5'd2;
    localparam logic [4:0] BASE_10 = 5'd10;
    localparam logic [4:0] BASE_16 = 5'd16;

    logic [3:0]      mode_reg, mode_next;
    logic [7:0]      la_reg, la_next;
    logic [PB-1:0]   pos_reg, pos_next;
    logic [31:0]     lines_reg, lines_next;
    logic [PB-1:0]   lso_reg, lso_next;
    logic [PB-1:0]   tstart_reg, tstart_next;
    logic [31:0]     tline_reg, tline_next;
    logic [PB-1:0]   tcol_reg, tcol_next;
    logic [63:0]     acc_reg, acc_next;
    logic [4:0]      base_reg, base_next;
    logic [14:0]     cand_reg, cand_next;
    logic [IL_W-1:0] il_reg, il_next;

    tok_t            slot_reg [3];
    tok_t            res_next [3];
    logic [1:0]      cnt_reg, cnt_next;
    logic [1:0]      head_reg;

    logic            src_fire, tok_fire;

    function automatic logic [3:0] ident_kw(input logic [14:0] cand,
                                            input logic [IL_W-1:0] il);
        logic [3:0] kw;
        kw = NO_KEYWORD;
        for (int k = KW_COUNT - 1; k >= 0; k--)
            if (cand[k] && (IL_W'(KW_LEN[k]) == il))
                kw = 4'(k);
        return kw;
    endfunction

    function automatic tok_t make_tok(input logic [5:0] kind, input logic [63:0] value,
                                      input logic [3:0] kw, input logic [31:0] start,
                                      input logic [31:0] len, input logic [31:0] line,
                                      input logic [31:0] col);
        tok_t t;
        t.kind  = kind;
        t.value = value;
        t.kw    = kw;
        t.start = start;
        t.len   = len;
        t.line  = line;
        t.col   = col;
        t.last  = 1'b0;
        return t;
    endfunction

    always_comb
    begin : lex
        logic [7:0]  c;
        logic        taken, cons;
        logic        pre_en, post_en, flush_en;
        logic [5:0]  pre_kind, post_kind, flush_kind;
        logic [63:0] pre_val, flush_val;
        logic [3:0]  pre_kw, flush_kw;
        logic [4:0]  dv;
        logic        dbad;
        logic [63:0] scaled;
        logic [5:0]  sk;
        op2_t        o;
        tok_t        t;

        c           = source_byte;
        mode_next   = mode_reg;
        la_next     = la_reg;
        pos_next    = pos_reg;
        lines_next  = lines_reg;
        lso_next    = lso_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        cand_next   = cand_reg;
        il_next     = il_reg;
        cnt_next    = 2'd0;
        for (int i = 0; i < 3; i++)
            res_next[i] = '0;

        taken     = 1'b1;
        cons      = 1'b0;
        pre_en    = 1'b0;
        post_en   = 1'b0;
        pre_kind  = K_EOF;
        post_kind = K_EOF;
        pre_val   = '0;
        pre_kw    = NO_KEYWORD;
        o         = op2_info(la_reg);
        sk        = single_kind(c);
        dv        = 5'd0;
        dbad      = 1'b0;
        scaled    = '0;
        flush_en   = 1'b0;
        flush_kind = K_EOF;
        flush_val  = '0;
        flush_kw   = NO_KEYWORD;

        case (mode_reg)
            M_SLASH:
            begin
                if (c == "/")
                begin
                    cons      = 1'b1;
                    mode_next = M_COMMENT;
                end
                else
                begin
                    pre_en    = 1'b1;
                    pre_kind  = K_DIVIDE;
                    mode_next = M_IDLE;
                    taken     = 1'b0;
                end
            end
            M_COMMENT:
            begin
                if (c == 8'h0a || c == 8'h00)
                begin
                    mode_next = M_IDLE;
                    taken     = 1'b0;
                end
                else
                    cons = 1'b1;
            end
            M_OP2:
            begin
                mode_next = M_IDLE;
                if (c == o.second)
                begin
                    cons      = 1'b1;
                    post_en   = 1'b1;
                    post_kind = o.twice;
                end
                else
                begin
                    pre_en   = 1'b1;
                    pre_kind = o.single;
                    taken    = 1'b0;
                end
            end
            M_ZERO:
            begin
                if (c == "x" || c == "b")
                begin
                    cons      = 1'b1;
                    base_next = (c == "x") ? BASE_16 : BASE_2;
                    acc_next  = '0;
                    mode_next = M_NUM;
                end
                else
                begin
                    mode_next = M_IDLE;
                    pre_en    = 1'b1;
                    pre_kind  = (is_digit(c) || is_alpha(c)) ? K_UNKNOWN : K_NUMBER;
                    taken     = 1'b0;
                end
            end
            M_NUM:
            begin
                if (is_digit(c))
                    dv = 5'(c - "0");
                else if (c >= "a" && c <= "f")
                    dv = 5'(c - "a") + 5'd10;
                else if (c >= "A" && c <= "F")
                    dv = 5'(c - "A") + 5'd10;
                else
                    dbad = 1'b1;
                case (base_reg)
                    BASE_16: scaled = {acc_reg[59:0], 4'd0};
                    BASE_2:  scaled = {acc_reg[62:0], 1'b0};
                    default: scaled = {acc_reg[60:0], 3'd0} + {acc_reg[62:0], 1'b0};
                endcase
                if (c == "_")
                    cons = 1'b1;
                else if (!is_alpha(c) && !is_digit(c))
                begin
                    mode_next = M_IDLE;
                    pre_en    = 1'b1;
                    pre_kind  = K_NUMBER;
                    pre_val   = acc_reg;
                    taken     = 1'b0;
                end
                else if (dbad || dv >= base_reg)
                begin
                    mode_next = M_IDLE;
                    pre_en    = 1'b1;
                    pre_kind  = K_UNKNOWN;
                    taken     = 1'b0;
                end
                else
                begin
                    acc_next = scaled + 64'(dv);
                    cons     = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (!is_ident(c))
                begin
                    mode_next = M_IDLE;
                    pre_en    = 1'b1;
                    pre_kw    = ident_kw(cand_reg, il_reg);
                    pre_kind  = (pre_kw == NO_KEYWORD) ? K_IDENT : K_KEYWORD;
                    taken     = 1'b0;
                end
                else
                    cons = 1'b1;
            end
            M_QUOTE_ID:
            begin
                if (c == 8'h27)
                begin
                    cons      = 1'b1;
                    mode_next = M_IDLE;
                    post_en   = 1'b1;
                    post_kind = K_CHAR;
                end
                else if (is_ident(c))
                begin
                    cons      = 1'b1;
                    mode_next = M_GENERIC;
                end
                else
                begin
                    mode_next = M_IDLE;
                    pre_en    = 1'b1;
                    pre_kind  = K_GENERIC;
                    taken     = 1'b0;
                end
            end
            M_GENERIC:
            begin
                if (is_ident(c))
                    cons = 1'b1;
                else
                begin
                    mode_next = M_IDLE;
                    pre_en    = 1'b1;
                    pre_kind  = K_GENERIC;
                    taken     = 1'b0;
                end
            end
            M_QUOTE, M_CHAR:
            begin
                cons = 1'b1;
                if (mode_reg == M_QUOTE && is_ident_start(c))
                    mode_next = M_QUOTE_ID;
                else if (c == 8'h27 || c == 8'h00)
                begin
                    mode_next = M_IDLE;
                    post_en   = 1'b1;
                    post_kind = K_CHAR;
                end
                else
                    mode_next = M_CHAR;
            end
            M_STRING:
            begin
                cons = 1'b1;
                if (c == 8'h22 || c == 8'h00)
                begin
                    mode_next = M_IDLE;
                    post_en   = 1'b1;
                    post_kind = K_STRING;
                end
            end
            M_DONE:
                taken = 1'b1;
            default:
                taken = 1'b0;
        endcase

        if (pre_en)
        begin
            res_next[cnt_next] = make_tok(pre_kind, pre_val, pre_kw, 32'(tstart_reg),
                32'(pos_reg - tstart_reg), tline_reg + 32'd1, 32'(tcol_reg));
            cnt_next = cnt_next + 2'd1;
        end

        if (!taken)
        begin
            if (c != 8'h00 && !(c inside {[8'd9:8'd13], 8'd32}))
            begin
                tstart_next = pos_reg;
                tline_next  = lines_reg;
                tcol_next   = pos_reg - lso_reg + PB'(1);
            end
            if (c == 8'h00)
            begin
                res_next[cnt_next] = make_tok(K_EOF, '0, NO_KEYWORD, 32'(pos_reg), 32'd0,
                    lines_reg + 32'd1, 32'(pos_reg - lso_reg + PB'(1)));
                cnt_next  = cnt_next + 2'd1;
                tstart_next = pos_reg;
                tline_next  = lines_reg;
                tcol_next   = pos_reg - lso_reg + PB'(1);
                mode_next = M_DONE;
            end
            else if (c inside {[8'd9:8'd13], 8'd32})
                cons = 1'b1;
            else
            begin
                cons = 1'b1;
                if (sk != K_EOF)
                begin
                    post_en   = 1'b1;
                    post_kind = sk;
                end
                else if (c inside {".", "=", "-", ":", "<", ">", "!"})
                begin
                    la_next   = c;
                    mode_next = M_OP2;
                end
                else if (c == "/")
                    mode_next = M_SLASH;
                else if (is_digit(c))
                begin
                    base_next = BASE_10;
                    acc_next  = 64'(c - "0");
                    mode_next = (c == "0") ? M_ZERO : M_NUM;
                end
                else if (c == 8'h27)
                    mode_next = M_QUOTE;
                else if (c == 8'h22)
                    mode_next = M_STRING;
                else if (is_ident_start(c))
                begin
                    cand_next = '1;
                    il_next   = '0;
                    mode_next = M_IDENT;
                end
                else
                begin
                    post_en   = 1'b1;
                    post_kind = K_UNKNOWN;
                end
            end
        end

        if (cons && mode_next == M_IDENT)
        begin
            if (int'(il_next) < MAX_KEYWORD_LENGTH && int'(il_next) < 8)
            begin
                for (int k = 0; k < KW_COUNT; k++)
                    if (kw_char(k, 3'(il_next)) != c)
                        cand_next[k] = 1'b0;
            end
            else
                cand_next = '0;
            if (int'(il_next) <= MAX_KEYWORD_LENGTH)
                il_next = il_next + IL_W'(1);
        end

        if (cons)
        begin
            if (c == 8'h09)
            begin
                res_next[cnt_next] = make_tok(K_TAB, '0, NO_KEYWORD, 32'(pos_reg), 32'd1,
                    lines_reg + 32'd1, 32'(pos_reg - lso_reg + PB'(1)));
                cnt_next = cnt_next + 2'd1;
            end
            else if (c == 8'h0a)
            begin
                lso_next   = pos_reg + PB'(1);
                lines_next = lines_reg + 32'd1;
            end
            pos_next = pos_reg + PB'(1);
        end

        if (post_en)
        begin
            res_next[cnt_next] = make_tok(post_kind, '0, NO_KEYWORD, 32'(tstart_next),
                32'(pos_next - tstart_next), tline_next + 32'd1, 32'(tcol_next));
            cnt_next = cnt_next + 2'd1;
        end

        if (end_of_input)
        begin
            flush_en = 1'b1;
            case (mode_next)
                M_SLASH:              flush_kind = K_DIVIDE;
                M_OP2:                flush_kind = op2_info(la_next).single;
                M_ZERO, M_NUM:
                begin
                    flush_kind = K_NUMBER;
                    flush_val  = acc_next;
                end
                M_IDENT:
                begin
                    flush_kw   = ident_kw(cand_next, il_next);
                    flush_kind = (flush_kw == NO_KEYWORD) ? K_IDENT : K_KEYWORD;
                end
                M_QUOTE_ID, M_GENERIC: flush_kind = K_GENERIC;
                M_QUOTE, M_CHAR:       flush_kind = K_CHAR;
                M_STRING:              flush_kind = K_STRING;
                default:               flush_en = 1'b0;
            endcase
            if (flush_en && cnt_next != 2'd3)
            begin
                res_next[cnt_next] = make_tok(flush_kind, flush_val, flush_kw,
                    32'(tstart_next), 32'(pos_next - tstart_next), tline_next + 32'd1,
                    32'(tcol_next));
                cnt_next = cnt_next + 2'd1;
            end
            if (mode_next != M_DONE && cnt_next != 2'd3)
            begin
                res_next[cnt_next] = make_tok(K_EOF, '0, NO_KEYWORD, 32'(pos_next), 32'd0,
                    lines_next + 32'd1, 32'(pos_next - lso_next + PB'(1)));
                cnt_next = cnt_next + 2'd1;
            end
            mode_next   = M_IDLE;
            la_next     = '0;
            pos_next    = '0;
            lines_next  = '0;
            lso_next    = '0;
            tstart_next = '0;
            tline_next  = '0;
            tcol_next   = '0;
            acc_next    = '0;
            base_next   = BASE_10;
            cand_next   = '1;
            il_next     = '0;
        end

        if (cnt_next != 2'd0)
        begin
            t = res_next[cnt_next - 2'd1];
            t.last = 1'b1;
            res_next[cnt_next - 2'd1] = t;
        end
        else
            t = '0;
    end

    assign tok_valid = (cnt_reg != 2'd0);
    assign src_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && tok_ready);
    assign src_fire  = src_valid && src_ready;
    assign tok_fire  = tok_valid && tok_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            la_reg     <= '0;
            pos_reg    <= '0;
            lines_reg  <= '0;
            lso_reg    <= '0;
            tstart_reg <= '0;
            tline_reg  <= '0;
            tcol_reg   <= '0;
            acc_reg    <= '0;
            base_reg   <= BASE_10;
            cand_reg   <= '1;
            il_reg     <= '0;
            cnt_reg    <= '0;
            head_reg   <= '0;
        end
        else if (src_fire)
        begin
            mode_reg   <= mode_next;
            la_reg     <= la_next;
            pos_reg    <= pos_next;
            lines_reg  <= lines_next;
            lso_reg    <= lso_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            acc_reg    <= acc_next;
            base_reg   <= base_next;
            cand_reg   <= cand_next;
            il_reg     <= il_next;
            cnt_reg    <= cnt_next;
            head_reg   <= '0;
        end
        else if (tok_fire)
        begin
            cnt_reg  <= cnt_reg - 2'd1;
            head_reg <= head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_fire)
            slot_reg <= res_next;
    end

    assign token_kind    = slot_reg[head_reg].kind;
    assign number_value  = slot_reg[head_reg].value;
    assign keyword_index = slot_reg[head_reg].kw;
    assign start_offset  = slot_reg[head_reg].start;
    assign token_length  = slot_reg[head_reg].len;
    assign line_number   = slot_reg[head_reg].line;
    assign column_number = slot_reg[head_reg].col;
    assign last_token    = slot_reg[head_reg].last;

endmodule

[src/srctok_checker.sv]
`include "source_tokenizer_top_macros.svh"

module srctok_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        src_ready,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic [5:0]  token_kind,
    input logic [31:0] token_length,
    input logic        last_token
);
    import srctok_pkg::*;

    // hold a stalled transaction
    `SRCTOK_ASSERT_NEXT(a_tok_hold, tok_valid && !tok_ready, tok_valid)
    // advance to the rest of a byte's tokens
    `SRCTOK_ASSERT_NEXT(a_group_cont, tok_valid && tok_ready && !last_token, tok_valid)
    `SRCTOK_ASSERT_NOW(a_ready_empty, !tok_valid, src_ready)
    `SRCTOK_ASSERT_NOW(a_eof_len, tok_valid && token_kind == K_EOF, token_length == 32'd0)

endmodule

bind source_tokenizer_top srctok_checker u_srctok_checker (.*);

[sim/tb_source_tokenizer_top.sv]
`timescale 1ns / 100ps

module tb_source_tokenizer_top;
    import srctok_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 84;
    localparam int POS_MAX_KW   = 6;

    typedef enum logic [3:0] {
        S_IDLE, S_SLASH, S_COMMENT, S_OP2, S_ZERO, S_NUM, S_IDENT, S_QUOTE,
        S_QUOTE_ID, S_CHAR, S_GENERIC, S_STRING, S_DONE
    } scan_e;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        bit         typed;
        logic [5:0] kind;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_ready;
    logic [7:0]  source_byte;
    logic        end_of_input;
    logic        tok_valid;
    logic        tok_ready;
    logic [5:0]  token_kind;
    logic [63:0] number_value;
    logic [3:0]  keyword_index;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic [31:0] column_number;
    logic        last_token;

    source_tokenizer_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_ready     (src_ready),
        .source_byte   (source_byte),
        .end_of_input  (end_of_input),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .token_kind    (token_kind),
        .number_value  (number_value),
        .keyword_index (keyword_index),
        .start_offset  (start_offset),
        .token_length  (token_length),
        .line_number   (line_number),
        .column_number (column_number),
        .last_token    (last_token)
    );

    // lexer state mirror
    scan_e       lx_mode;
    logic [7:0]  lx_pending_op;
    logic [31:0] lx_pos;
    logic [31:0] lx_lines;
    logic [31:0] lx_line_start;
    logic [31:0] lx_tok_start;
    logic [31:0] lx_tok_line;
    logic [31:0] lx_tok_col;
    logic [63:0] lx_acc;
    logic [63:0] lx_base;
    logic [14:0] lx_cand;
    int          lx_id_len;

    tok_t step_tokens[$];
    tok_t expected_tokens[$];

    int src_idle_pct;
    int rcv_idle_pct;
    int hold_req_cnt;
    int hold_seen_cnt;
    int hold_left;
    int cycle_cnt;
    int mismatch_cnt;
    int tokens_checked;
    int bytes_sent;
    int files_sent;

    always #5 clk = ~clk;

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_id_first(logic [7:0] c);
        return is_letter(c) || c == "_";
    endfunction

    function automatic bit is_id_char(logic [7:0] c);
        return is_id_first(c) || is_dig(c);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] keyword_char(int k, int p);
        if (p >= int'(KW_LEN[k]))
            return 8'd0;
        return KW_WORD[k][8 * (int'(KW_LEN[k]) - 1 - p) +: 8];
    endfunction

    function automatic void reset_scan();
        lx_mode       = S_IDLE;
        lx_pending_op = 8'd0;
        lx_pos        = '0;
        lx_lines      = '0;
        lx_line_start = '0;
        lx_tok_start  = '0;
        lx_tok_line   = '0;
        lx_tok_col    = '0;
        lx_acc        = '0;
        lx_base       = 64'd10;
        lx_cand       = 15'h7fff;
        lx_id_len     = 0;
    endfunction

    function automatic void put_token(logic [5:0] kind, logic [63:0] value, logic [3:0] kw,
                                      logic [31:0] start, logic [31:0] len,
                                      logic [31:0] line, logic [31:0] col);
        tok_t t;
        if (step_tokens.size() >= 3)
            return;
        t = '{kind, value, kw, start, len, line, col, 1'b0};
        step_tokens.push_back(t);
    endfunction

    function automatic void open_token();
        lx_tok_start = lx_pos;
        lx_tok_line  = lx_lines;
        lx_tok_col   = lx_pos - lx_line_start + 32'd1;
    endfunction

    function automatic void close_token(logic [5:0] kind, logic [63:0] value, logic [3:0] kw);
        put_token(kind, value, kw, lx_tok_start, lx_pos - lx_tok_start,
                  lx_tok_line + 32'd1, lx_tok_col);
    endfunction

    function automatic void take_byte(logic [7:0] c);
        if (c == 8'h09)
            put_token(K_TAB, '0, NO_KEYWORD, lx_pos, 32'd1, lx_lines + 32'd1,
                      lx_pos - lx_line_start + 32'd1);
        else if (c == 8'h0a) begin
            lx_line_start = lx_pos + 32'd1;
            lx_lines      = lx_lines + 32'd1;
        end
        lx_pos = lx_pos + 32'd1;
    endfunction

    function automatic void narrow_keywords(logic [7:0] c);
        if (lx_id_len < POS_MAX_KW) begin
            for (int k = 0; k < KW_COUNT; k++)
                if (keyword_char(k, lx_id_len) != c)
                    lx_cand[k] = 1'b0;
        end
        else
            lx_cand = '0;
        if (lx_id_len <= POS_MAX_KW)
            lx_id_len++;
    endfunction

    function automatic void close_ident();
        for (int k = 0; k < KW_COUNT; k++)
            if (lx_cand[k] && int'(KW_LEN[k]) == lx_id_len) begin
                close_token(K_KEYWORD, '0, 4'(k));
                return;
            end
        close_token(K_IDENT, '0, NO_KEYWORD);
    endfunction

    function automatic void pair_kinds(logic [7:0] first, output logic [5:0] one,
                                       output logic [7:0] next, output logic [5:0] two);
        next = "=";
        case (first)
            ".":     begin one = K_DOT;    next = "."; two = K_DDOT;  end
            "=":     begin one = K_ASSIGN; two = K_EQ;                end
            "-":     begin one = K_MINUS;  next = ">"; two = K_ARROW; end
            ":":     begin one = K_COLON;  two = K_DEFINE;            end
            "<":     begin one = K_LT;     two = K_LE;                end
            ">":     begin one = K_GT;     two = K_GE;                end
            default: begin one = K_NOT;    two = K_NE;                end
        endcase
    endfunction

    function automatic logic [5:0] lone_kind(logic [7:0] c);
        case (c)
            ",":     return K_COMMA;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "[":     return K_LBRACK;
            "]":     return K_RBRACK;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            "+":     return K_PLUS;
            ";":     return K_SEMI;
            "|":     return K_BAR;
            "*":     return K_STAR;
            "#":     return K_HASH;
            default: return K_EOF;
        endcase
    endfunction

    function automatic void lex_fresh(logic [7:0] c);
        logic [5:0] k;
        k = lone_kind(c);
        if (c == 8'd0) begin
            open_token();
            close_token(K_EOF, '0, NO_KEYWORD);
            lx_mode = S_DONE;
            return;
        end
        if (is_blank(c)) begin
            take_byte(c);
            return;
        end
        open_token();
        if (k != K_EOF) begin
            take_byte(c);
            close_token(k, '0, NO_KEYWORD);
        end
        else if (c == "." || c == "=" || c == "-" || c == ":" || c == "<" || c == ">"
                 || c == "!") begin
            lx_pending_op = c;
            take_byte(c);
            lx_mode = S_OP2;
        end
        else if (c == "/") begin
            take_byte(c);
            lx_mode = S_SLASH;
        end
        else if (is_dig(c)) begin
            take_byte(c);
            lx_base = 64'd10;
            lx_acc  = 64'(c - "0");
            lx_mode = (c == "0") ? S_ZERO : S_NUM;
        end
        else if (c == "'") begin
            take_byte(c);
            lx_mode = S_QUOTE;
        end
        else if (c == "\"") begin
            take_byte(c);
            lx_mode = S_STRING;
        end
        else if (is_id_first(c)) begin
            lx_cand   = 15'h7fff;
            lx_id_len = 0;
            narrow_keywords(c);
            take_byte(c);
            lx_mode = S_IDENT;
        end
        else begin
            take_byte(c);
            close_token(K_UNKNOWN, '0, NO_KEYWORD);
        end
    endfunction

    // returns 0 when the byte ends the open token or comment and must be lexed again
    function automatic bit lex_in_mode(logic [7:0] c);
        logic [5:0] one, two;
        logic [7:0] next;
        logic [63:0] v;
        case (lx_mode)
            S_SLASH: begin
                if (c == "/") begin
                    take_byte(c);
                    lx_mode = S_COMMENT;
                    return 1;
                end
                close_token(K_DIVIDE, '0, NO_KEYWORD);
                lx_mode = S_IDLE;
                return 0;
            end
            S_COMMENT: begin
                if (c == 8'h0a || c == 8'd0) begin
                    lx_mode = S_IDLE;
                    return 0;
                end
                take_byte(c);
                return 1;
            end
            S_OP2: begin
                pair_kinds(lx_pending_op, one, next, two);
                lx_mode = S_IDLE;
                if (c == next) begin
                    take_byte(c);
                    close_token(two, '0, NO_KEYWORD);
                    return 1;
                end
                close_token(one, '0, NO_KEYWORD);
                return 0;
            end
            S_ZERO: begin
                if (c == "x" || c == "b") begin
                    take_byte(c);
                    lx_base = (c == "x") ? 64'd16 : 64'd2;
                    lx_acc  = '0;
                    lx_mode = S_NUM;
                    return 1;
                end
                lx_mode = S_IDLE;
                if (is_dig(c) || is_letter(c))
                    close_token(K_UNKNOWN, '0, NO_KEYWORD);
                else
                    close_token(K_NUMBER, '0, NO_KEYWORD);
                return 0;
            end
            S_NUM: begin
                if (c == "_") begin
                    take_byte(c);
                    return 1;
                end
                if (is_dig(c))
                    v = 64'(c - "0");
                else if (c >= "a" && c <= "f")
                    v = 64'(c - "a") + 64'd10;
                else if (c >= "A" && c <= "F")
                    v = 64'(c - "A") + 64'd10;
                else if (is_letter(c))
                    v = 64'd99;
                else begin
                    lx_mode = S_IDLE;
                    close_token(K_NUMBER, lx_acc, NO_KEYWORD);
                    return 0;
                end
                if (v >= lx_base) begin
                    lx_mode = S_IDLE;
                    close_token(K_UNKNOWN, '0, NO_KEYWORD);
                    return 0;
                end
                lx_acc = lx_acc * lx_base + v;
                take_byte(c);
                return 1;
            end
            S_IDENT: begin
                if (is_id_char(c)) begin
                    narrow_keywords(c);
                    take_byte(c);
                    return 1;
                end
                lx_mode = S_IDLE;
                close_ident();
                return 0;
            end
            S_QUOTE_ID: begin
                if (c == "'") begin
                    take_byte(c);
                    lx_mode = S_IDLE;
                    close_token(K_CHAR, '0, NO_KEYWORD);
                    return 1;
                end
                if (is_id_char(c)) begin
                    take_byte(c);
                    lx_mode = S_GENERIC;
                    return 1;
                end
                lx_mode = S_IDLE;
                close_token(K_GENERIC, '0, NO_KEYWORD);
                return 0;
            end
            S_GENERIC: begin
                if (is_id_char(c)) begin
                    take_byte(c);
                    return 1;
                end
                lx_mode = S_IDLE;
                close_token(K_GENERIC, '0, NO_KEYWORD);
                return 0;
            end
            S_QUOTE, S_CHAR: begin
                if (lx_mode == S_QUOTE && is_id_first(c)) begin
                    take_byte(c);
                    lx_mode = S_QUOTE_ID;
                    return 1;
                end
                lx_mode = S_CHAR;
                take_byte(c);
                if (c == "'" || c == 8'd0) begin
                    lx_mode = S_IDLE;
                    close_token(K_CHAR, '0, NO_KEYWORD);
                end
                return 1;
            end
            S_STRING: begin
                take_byte(c);
                if (c == "\"" || c == 8'd0) begin
                    lx_mode = S_IDLE;
                    close_token(K_STRING, '0, NO_KEYWORD);
                end
                return 1;
            end
            S_DONE:
                return 1;
            default: begin
                lex_fresh(c);
                return 1;
            end
        endcase
    endfunction

    function automatic void close_file();
        logic [5:0] one, two;
        logic [7:0] next;
        case (lx_mode)
            S_SLASH: close_token(K_DIVIDE, '0, NO_KEYWORD);
            S_OP2: begin
                pair_kinds(lx_pending_op, one, next, two);
                close_token(one, '0, NO_KEYWORD);
            end
            S_ZERO, S_NUM: close_token(K_NUMBER, lx_acc, NO_KEYWORD);
            S_IDENT: close_ident();
            S_QUOTE_ID, S_GENERIC: close_token(K_GENERIC, '0, NO_KEYWORD);
            S_QUOTE, S_CHAR: close_token(K_CHAR, '0, NO_KEYWORD);
            S_STRING: close_token(K_STRING, '0, NO_KEYWORD);
            default: ;
        endcase
        if (lx_mode != S_DONE) begin
            open_token();
            close_token(K_EOF, '0, NO_KEYWORD);
        end
    endfunction

    function automatic void lex_byte(logic [7:0] c, logic eoi, bit typed, logic [5:0] kind);
        int n;
        step_tokens.delete();
        if (lx_mode == S_IDLE)
            lex_fresh(c);
        else if (!lex_in_mode(c))
            lex_fresh(c);
        if (eoi) begin
            close_file();
            reset_scan();
        end
        n = step_tokens.size();
        if (n > 0) begin
            step_tokens[n - 1].last = 1'b1;
            if (typed)
                step_tokens[n - 1].kind = kind;
        end
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endfunction

    task automatic send_byte(logic [7:0] c, logic eoi, bit typed, logic [5:0] kind);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid    <= 1'b1;
        source_byte  <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        lex_byte(c, eoi, typed, kind);
        bytes_sent++;
        if (eoi)
            files_sent++;
    endtask

    task automatic add_fragment(ref logic [7:0] q[$]);
        string hexd;
        string pair_first;
        string pair_second;
        string singles;
        string blanks;
        int n, k;
        hexd        = "0123456789abcdefABCDEF";
        pair_first  = ".=-:<>!";
        pair_second = ".=>";
        singles     = ",()[]{}+;|*#/";
        blanks      = " \n\t\r";
        case ($urandom_range(0, 12))
            0: begin
                k = $urandom_range(0, KW_COUNT - 1);
                for (int p = 0; p < int'(KW_LEN[k]); p++)
                    q.push_back(keyword_char(k, p));
            end
            1: begin
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                    case ($urandom_range(0, 3))
                        0: q.push_back(8'($urandom_range("A", "Z")));
                        1: q.push_back(i == 0 ? "_" : 8'($urandom_range("0", "9")));
                        default: q.push_back(8'($urandom_range("a", "z")));
                    endcase
            end
            2: begin
                n = $urandom_range(1, 22);
                q.push_back(8'($urandom_range("1", "9")));
                for (int i = 1; i < n; i++)
                    q.push_back($urandom_range(0, 5) == 0 ? "_" : 8'($urandom_range("0", "9")));
            end
            3: begin
                q.push_back("0");
                q.push_back("x");
                n = $urandom_range(1, 18);
                for (int i = 0; i < n; i++)
                    q.push_back(hexd[$urandom_range(0, 21)]);
            end
            4: begin
                q.push_back("0");
                q.push_back("b");
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    q.push_back($urandom_range(0, 1) ? "1" : "0");
            end
            5: begin
                q.push_back(pair_first[$urandom_range(0, 6)]);
                if ($urandom_range(0, 1))
                    q.push_back(pair_second[$urandom_range(0, 2)]);
            end
            6: q.push_back(singles[$urandom_range(0, 12)]);
            7: begin
                q.push_back("\"");
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                    q.push_back(8'($urandom_range(32, 126)));
                q.push_back("\"");
            end
            8: begin
                q.push_back("'");
                case ($urandom_range(0, 2))
                    0: begin
                        q.push_back(8'($urandom_range(32, 126)));
                        q.push_back("'");
                    end
                    1: begin
                        q.push_back(8'($urandom_range("a", "z")));
                        q.push_back("'");
                    end
                    default: begin
                        q.push_back("T");
                        q.push_back(8'($urandom_range("a", "z")));
                    end
                endcase
            end
            9: begin
                q.push_back("/");
                q.push_back("/");
                q.push_back(8'($urandom_range(1, 255)));
                q.push_back(8'h0a);
            end
            10: q.push_back(blanks[$urandom_range(0, 3)]);
            11: q.push_back($urandom_range(0, 30) == 0 ? 8'd0 : 8'($urandom_range(1, 255)));
            default: begin
                q.push_back("0");
                q.push_back($urandom_range(0, 1) ? "7" : "q");
                q.push_back("1");
                q.push_back("z");
            end
        endcase
        if ($urandom_range(0, 1))
            q.push_back(" ");
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_ready     <= 1'b0;
            hold_seen_cnt <= 0;
            hold_left     <= 0;
        end
        else if (hold_seen_cnt != hold_req_cnt) begin
            hold_seen_cnt <= hold_req_cnt;
            hold_left     <= LONG_HOLD;
            tok_ready     <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            tok_ready <= 1'b0;
        end
        else
            tok_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        tok_t exp_tok, got;
        if (rst_n && tok_valid && tok_ready) begin
            got = '{token_kind, number_value, keyword_index, start_offset, token_length,
                    line_number, column_number, last_token};
            if (expected_tokens.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected token: %p", got);
            end
            else begin
                exp_tok = expected_tokens.pop_front();
                tokens_checked++;
                if (got !== exp_tok) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("token mismatch\n  expected %p\n  actual   %p", exp_tok, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        logic [7:0] file_q[$];
        int sent;
        bit held, paused;

        clk          = 1'b0;
        rst_n        = 1'b0;
        src_valid    = 1'b0;
        source_byte  = 8'd0;
        end_of_input = 1'b0;
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req_cnt = 0;
        cycle_cnt    = 0;
        mismatch_cnt = 0;
        tokens_checked = 0;
        bytes_sent   = 0;
        files_sent   = 0;
        reset_scan();

        rows = '{
            '{"l", 0, 0, K_EOF}, '{"e", 0, 0, K_EOF}, '{"t", 0, 0, K_EOF},
            '{" ", 0, 1, K_KEYWORD},
            '{"0", 0, 0, K_EOF}, '{"x", 0, 0, K_EOF}, '{"F", 0, 0, K_EOF},
            '{"f", 0, 0, K_EOF}, '{";", 0, 1, K_SEMI},
            '{"-", 0, 0, K_EOF}, '{">", 0, 1, K_ARROW},
            '{8'h09, 0, 1, K_TAB},
            '{"'", 0, 0, K_EOF}, '{"a", 0, 0, K_EOF}, '{"'", 0, 1, K_CHAR},
            '{"\"", 0, 0, K_EOF}, '{8'h00, 0, 1, K_STRING},
            '{"/", 0, 0, K_EOF}, '{"/", 0, 0, K_EOF}, '{8'h0a, 0, 0, K_EOF},
            '{"0", 0, 0, K_EOF}, '{"9", 0, 1, K_UNKNOWN},
            '{8'hff, 0, 1, K_UNKNOWN}, '{"!", 1, 1, K_EOF},
            '{8'h00, 0, 1, K_EOF}, '{"a", 1, 0, K_EOF}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_byte(rows[i].ch, rows[i].eoi, rows[i].typed, rows[i].kind);

        sent   = 0;
        held   = 0;
        paused = 0;
        while (sent < RANDOM_ITEMS) begin
            file_q.delete();
            repeat ($urandom_range(2, 8))
                add_fragment(file_q);
            foreach (file_q[i]) begin
                if (sent < RANDOM_ITEMS / 3) begin
                    src_idle_pct = 21;
                    rcv_idle_pct = 76;
                end
                else if (sent < 2 * RANDOM_ITEMS / 3) begin
                    src_idle_pct = 76;
                    rcv_idle_pct = 21;
                end
                else begin
                    src_idle_pct = 0;
                    rcv_idle_pct = 0;
                    if (!held) begin
                        held = 1;
                        hold_req_cnt++;
                    end
                    else if (!paused && sent >= 5 * RANDOM_ITEMS / 6) begin
                        paused = 1;
                        src_valid <= 1'b0;
                        wait (expected_tokens.size() == 0);
                        @(posedge clk);
                    end
                end
                send_byte(file_q[i], (i == file_q.size() - 1) || (sent == RANDOM_ITEMS - 1),
                          0, K_EOF);
                sent++;
                if (sent >= RANDOM_ITEMS)
                    break;
            end
        end
        src_valid    <= 1'b0;
        end_of_input <= 1'b0;

        wait (expected_tokens.size() == 0);
        repeat (20) @(posedge clk);

        $display("sent %0d bytes in %0d files, checked %0d tokens, %0d mismatches",
                 bytes_sent, files_sent, tokens_checked, mismatch_cnt);
        $display("covered operators, numbers in three bases, keywords, literals, comments, ",
                 "tabs, unknown bytes and stalls on both sides");
        if (mismatch_cnt == 0 && expected_tokens.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/srctok_pkg.sv
src/source_tokenizer_top.sv
src/srctok_checker.sv
sim/tb_source_tokenizer_top.sv
